/* src/gcd_pkg.sv */
// Shared constants, types and table functions for the great-circle distance pipeline.
// Used by the stream interfaces, the CORDIC and square-root cells, and the top level.
package gcd_pkg;

  localparam int ANGLE_FRACTION_BITS = 22;
  localparam int CORDIC_STAGES       = 24;

  localparam int LAT_W    = 30;
  localparam int LON_W    = 31;
  localparam int RADIUS_W = 26;
  localparam int DIST_W   = 35;

  // CORDIC datapath width: values stay below about 2.4 in Q F.
  localparam int DW   = ANGLE_FRACTION_BITS + 4;
  localparam int SH_W = $clog2(CORDIC_STAGES);

  // Square-root datapath: radicand is at most 2^(2F).
  localparam int SQ_W     = 2 * ANGLE_FRACTION_BITS + 2;
  localparam int SQ_STEPS = ANGLE_FRACTION_BITS + 1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 26'd6371000;

  localparam longint PI_Q60   = 64'sh3243F6A8885A308D;
  localparam longint GAIN_Q30 = 64'sh26DD3B6A;
  localparam longint DEG2RAD_Q32 = ((PI_Q60 / 180) + (64'sd1 <<< 27)) >>> 28;

  localparam int D2R_W = 27;
  localparam logic [D2R_W-1:0] DEG2RAD = D2R_W'(DEG2RAD_Q32);

  localparam logic signed [DW-1:0] CORDIC_X0 =
    DW'((GAIN_Q30 + (64'sd1 <<< (29 - ANGLE_FRACTION_BITS))) >>> (30 - ANGLE_FRACTION_BITS));

  // Degrees in Q22.
  localparam logic signed [32:0] TURN_FULL = 33'sd1509949440;
  localparam logic signed [32:0] TURN_HALF = 33'sd754974720;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  // Arctangent of 2^-i from its Taylor series in Q60, rounded to Q F at elaboration.
  function automatic logic signed [DW-1:0] atan_entry(input int i);
    longint v;
    longint term;
    int     e;
    v = 0;
    if (i == 0) begin
      v = PI_Q60 >>> 2;
    end else begin
      for (int k = 0; k < 61; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          term = longint'((64'd1 << e) / 64'(2 * k + 1));
          v = k[0] ? v - term : v + term;
        end
      end
    end
    return DW'((v + (64'sd1 <<< (59 - ANGLE_FRACTION_BITS))) >>> (60 - ANGLE_FRACTION_BITS));
  endfunction

endpackage

/* src/gcd_stream_if.sv */
// Valid/ready stream interfaces for point pairs and distance items.
// Depends on gcd_pkg for the field widths.
interface gcd_in_if;
  import gcd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] first_latitude;
  logic signed [LON_W-1:0] first_longitude;
  logic signed [LAT_W-1:0] second_latitude;
  logic signed [LON_W-1:0] second_longitude;

  modport source (output valid, first_latitude, first_longitude, second_latitude,
                  second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude, second_latitude,
                second_longitude, output ready);
endinterface

interface gcd_out_if;
  import gcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_cm;

  modport source (output valid, distance_cm, input ready);
  modport sink (input valid, distance_cm, output ready);
endinterface

/* src/gcd_cordic_cell.sv */
// One CORDIC micro-rotation step, rotation or vectoring mode, with its output register.
// Depends on gcd_pkg for the datapath width and the cordic_t type.
module gcd_cordic_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            vec_mode,
  input  logic [gcd_pkg::SH_W-1:0]        shift,
  input  logic signed [gcd_pkg::DW-1:0]   atan_val,
  input  gcd_pkg::cordic_t                d_in,
  output gcd_pkg::cordic_t                d_out
);
  import gcd_pkg::*;

  cordic_t              d_r;
  cordic_t              d_nxt;
  logic signed [DW-1:0] xi;
  logic signed [DW-1:0] yi;
  logic signed [DW-1:0] zi;
  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  logic                 pos;

  always_comb begin
    xi = d_in.x;
    yi = d_in.y;
    zi = d_in.z;
    xs = xi >>> shift;
    ys = yi >>> shift;
    // Rotation drives z toward zero, vectoring drives y toward zero.
    pos = vec_mode ? (yi <= 0) : (zi >= 0);
    if (pos) begin
      d_nxt.x = xi - ys;
      d_nxt.y = yi + xs;
      d_nxt.z = zi - atan_val;
    end else begin
      d_nxt.x = xi + ys;
      d_nxt.y = yi - xs;
      d_nxt.z = zi + atan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

/* src/gcd_isqrt_cell.sv */
// One digit step of the bitwise integer square root, with its output register.
// Depends on gcd_pkg for the sqrt_t type.
module gcd_isqrt_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [gcd_pkg::SQ_W-1:0]   bit_val,
  input  gcd_pkg::sqrt_t             d_in,
  output gcd_pkg::sqrt_t             d_out
);
  import gcd_pkg::*;

  sqrt_t           d_r;
  sqrt_t           d_nxt;
  logic [SQ_W-1:0] trial;

  always_comb begin
    trial = d_in.res + bit_val;
    if (d_in.v >= trial) begin
      d_nxt.v   = d_in.v - trial;
      d_nxt.res = (d_in.res >> 1) + bit_val;
    end else begin
      d_nxt.v   = d_in.v;
      d_nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

/* src/great_circle_distance.sv */
// Great-circle distance pipeline: haversine term, square roots and atan2 by cell chains.
// Accepts one item per cycle while out_ch.ready does not stall it; each stage holds its item
// only while the stage after it is full.
// A synchronous low rst_n empties the pipeline and sets the radius to 6371000 m.
// Depends on gcd_pkg, gcd_stream_if, gcd_cordic_cell and gcd_isqrt_cell.
module great_circle_distance (
  input  logic        clk,
  input  logic        rst_n,
  gcd_in_if.sink      in_ch,
  gcd_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gcd_pkg::*;

  localparam int F        = ANGLE_FRACTION_BITS;
  localparam int ST_IN    = 0;
  localparam int ST_WRAP  = 1;
  localparam int ST_FOLD  = 2;
  localparam int ST_MUL   = 3;
  localparam int ST_RAD   = 4;
  localparam int ST_ROT0  = 5;
  localparam int ST_SQ    = ST_ROT0 + CORDIC_STAGES;
  localparam int ST_RF    = ST_SQ + 1;
  localparam int ST_CMUL  = ST_SQ + 2;
  localparam int ST_A     = ST_SQ + 3;
  localparam int ST_SQRT0 = ST_A + 1;
  localparam int ST_VEC0  = ST_SQRT0 + SQ_STEPS;
  localparam int ST_RMUL  = ST_VEC0 + CORDIC_STAGES;
  localparam int ST_M200  = ST_RMUL + 1;
  localparam int ST_OUT   = ST_RMUL + 2;
  localparam int N_ST     = ST_OUT + 1;

  localparam int MW   = LAT_W + D2R_W;
  localparam int PW   = 2 * DW;
  localparam int HW   = F + 6;
  localparam int CPW  = 2 * HW;
  localparam int AW   = F + 1;
  localparam int ZCW  = DW - 1;
  localparam int ZRW  = ZCW + RADIUS_W;
  localparam int M2W  = ZRW + 8;

  localparam logic [LAT_W-1:0] HALF_M    = 30'd754974720;
  localparam logic [LAT_W-1:0] QUARTER_M = 30'd377487360;

  logic [N_ST-1:0] v_r;
  logic [N_ST-1:0] en;
  logic [N_ST-1:0] v_in;

  logic [RADIUS_W-1:0] radius_r;

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      radius_r <= cfg_pwdata[RADIUS_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {{(32-RADIUS_W){1'b0}}, radius_r} : 32'd0;

  // A stage may load when it is empty or when its successor loads.
  always_comb begin
    en[N_ST-1] = !v_r[N_ST-1] || out_ch.ready;
    for (int k = N_ST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign v_in = {v_r[N_ST-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N_ST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  assign in_ch.ready = en[ST_IN];

  function automatic logic signed [LAT_W:0] wrap_deg(input logic signed [32:0] d);
    logic signed [32:0] r;
    r = d;
    if (d >= TURN_HALF) begin
      r = d - TURN_FULL;
    end else if (d < -TURN_HALF) begin
      r = d + TURN_FULL;
    end
    return (LAT_W+1)'(r);
  endfunction

  function automatic logic [LAT_W-1:0] mag_lat(input logic signed [LAT_W-1:0] a);
    return a[LAT_W-1] ? LAT_W'(-a) : LAT_W'(a);
  endfunction

  function automatic logic [LAT_W-1:0] mag_wrap(input logic signed [LAT_W:0] a);
    return a[LAT_W] ? LAT_W'(-a) : LAT_W'(a);
  endfunction

  // Input register: differences of the coordinates.
  logic signed [LAT_W-1:0] lat1_r, lat2_r;
  logic signed [LAT_W:0]   dlat_r;
  logic signed [LON_W:0]   dlon_r;

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      lat1_r <= in_ch.first_latitude;
      lat2_r <= in_ch.second_latitude;
      dlat_r <= (LAT_W+1)'(in_ch.second_latitude) - (LAT_W+1)'(in_ch.first_latitude);
      dlon_r <= (LON_W+1)'(in_ch.second_longitude) - (LON_W+1)'(in_ch.first_longitude);
    end
  end

  // Wrap the differences into one turn; latitudes are already in range.
  logic signed [LAT_W:0] wlat_r, wlon_r;
  logic [LAT_W-1:0]      alat1_r, alat2_r;

  always_ff @(posedge clk) begin
    if (en[ST_WRAP]) begin
      wlat_r  <= wrap_deg(33'(dlat_r));
      wlon_r  <= wrap_deg(33'(dlon_r));
      alat1_r <= mag_lat(lat1_r);
      alat2_r <= mag_lat(lat2_r);
    end
  end

  // Magnitudes, and latitudes folded into the first quadrant for the cosine.
  logic [LAT_W-1:0] hm_r [2];
  logic [LAT_W-1:0] cm_r [2];
  logic [1:0]       cneg2_r;

  always_ff @(posedge clk) begin
    if (en[ST_FOLD]) begin
      hm_r[0] <= mag_wrap(wlat_r);
      hm_r[1] <= mag_wrap(wlon_r);
      if (alat1_r > QUARTER_M) begin
        cm_r[0]    <= HALF_M - alat1_r;
        cneg2_r[0] <= 1'b1;
      end else begin
        cm_r[0]    <= alat1_r;
        cneg2_r[0] <= 1'b0;
      end
      if (alat2_r > QUARTER_M) begin
        cm_r[1]    <= HALF_M - alat2_r;
        cneg2_r[1] <= 1'b1;
      end else begin
        cm_r[1]    <= alat2_r;
        cneg2_r[1] <= 1'b0;
      end
    end
  end

  // Degrees to radians.
  logic [MW-1:0] prod_r [4];
  logic [1:0]    cneg3_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      prod_r[0] <= MW'(hm_r[0]) * MW'(DEG2RAD);
      prod_r[1] <= MW'(hm_r[1]) * MW'(DEG2RAD);
      prod_r[2] <= MW'(cm_r[0]) * MW'(DEG2RAD);
      prod_r[3] <= MW'(cm_r[1]) * MW'(DEG2RAD);
      cneg3_r   <= cneg2_r;
    end
  end

  // Haversine angles carry one more halving than the cosine angles.
  cordic_t    rot0_r [4];
  logic [1:0] cneg_r [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (en[ST_RAD]) begin
      for (int p = 0; p < 4; p++) begin
        rot0_r[p].x <= CORDIC_X0;
        rot0_r[p].y <= '0;
      end
      rot0_r[0].z <= DW'((prod_r[0] + (MW'(1) << (54 - F))) >> (55 - F));
      rot0_r[1].z <= DW'((prod_r[1] + (MW'(1) << (54 - F))) >> (55 - F));
      rot0_r[2].z <= DW'((prod_r[2] + (MW'(1) << (53 - F))) >> (54 - F));
      rot0_r[3].z <= DW'((prod_r[3] + (MW'(1) << (53 - F))) >> (54 - F));
      cneg_r[0]   <= cneg3_r;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (en[ST_ROT0+i]) begin
        cneg_r[i+1] <= cneg_r[i];
      end
    end
  end

  // Four rotation chains: sin(dlat/2), sin(dlon/2), cos(lat1), cos(lat2).
  cordic_t rot_w [4][CORDIC_STAGES];

  for (genvar p = 0; p < 4; p++) begin : g_rot
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      cordic_t cin;
      if (i == 0) begin : g_first
        assign cin = rot0_r[p];
      end else begin : g_next
        assign cin = rot_w[p][i-1];
      end
      gcd_cordic_cell u_cell (
        .clk      (clk),
        .en       (en[ST_ROT0+i]),
        .vec_mode (1'b0),
        .shift    (SH_W'(i)),
        .atan_val (atan_entry(i)),
        .d_in     (cin),
        .d_out    (rot_w[p][i])
      );
    end
  end

  // Haversine term assembly.
  logic signed [DW-1:0]  slat, slon, c1, c2;
  logic signed [PW-1:0]  sql_r, sqn_r, ccp_r;
  logic signed [HW-1:0]  hlat_r, hlon_r, cc_r, hlat2_r;
  logic signed [CPW-1:0] cp_r;
  logic signed [HW:0]    asum;
  logic [AW-1:0]         a_val;
  sqrt_t                 sq0_r [2];

  always_comb begin
    slat = rot_w[0][CORDIC_STAGES-1].y;
    slon = rot_w[1][CORDIC_STAGES-1].y;
    c1   = rot_w[2][CORDIC_STAGES-1].x;
    c2   = rot_w[3][CORDIC_STAGES-1].x;
    if (cneg_r[CORDIC_STAGES][0]) begin
      c1 = -c1;
    end
    if (cneg_r[CORDIC_STAGES][1]) begin
      c2 = -c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      sql_r <= PW'(slat) * PW'(slat);
      sqn_r <= PW'(slon) * PW'(slon);
      ccp_r <= PW'(c1) * PW'(c2);
    end
    if (en[ST_RF]) begin
      hlat_r <= HW'((sql_r + (PW'(1) <<< (F - 1))) >>> F);
      hlon_r <= HW'((sqn_r + (PW'(1) <<< (F - 1))) >>> F);
      cc_r   <= HW'((ccp_r + (PW'(1) <<< (F - 1))) >>> F);
    end
    if (en[ST_CMUL]) begin
      hlat2_r <= hlat_r;
      cp_r    <= CPW'(cc_r) * CPW'(hlon_r);
    end
  end

  // Clamp the term to [0, 1] and form both radicands.
  always_comb begin
    asum = (HW+1)'(hlat2_r) + (HW+1)'((cp_r + (CPW'(1) <<< (F - 1))) >>> F);
    if (asum < 0) begin
      a_val = '0;
    end else if (asum > ((HW+1)'(1) <<< F)) begin
      a_val = AW'(1) << F;
    end else begin
      a_val = AW'(asum);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_A]) begin
      sq0_r[0].v   <= SQ_W'(a_val) << F;
      sq0_r[0].res <= '0;
      sq0_r[1].v   <= SQ_W'((AW'(1) << F) - a_val) << F;
      sq0_r[1].res <= '0;
    end
  end

  // Square roots of a and 1-a, one result bit per cell.
  sqrt_t sq_w [2][SQ_STEPS];

  for (genvar q = 0; q < 2; q++) begin : g_sqrt
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_cell
      sqrt_t sin_d;
      if (j == 0) begin : g_first
        assign sin_d = sq0_r[q];
      end else begin : g_next
        assign sin_d = sq_w[q][j-1];
      end
      gcd_isqrt_cell u_cell (
        .clk     (clk),
        .en      (en[ST_SQRT0+j]),
        .bit_val (SQ_W'(1) << (2 * (SQ_STEPS - 1 - j))),
        .d_in    (sin_d),
        .d_out   (sq_w[q][j])
      );
    end
  end

  // Vectoring chain: atan2(sqrt(a), sqrt(1-a)).
  cordic_t vec0;
  cordic_t vec_w [CORDIC_STAGES];

  assign vec0.x = DW'(sq_w[1][SQ_STEPS-1].res);
  assign vec0.y = DW'(sq_w[0][SQ_STEPS-1].res);
  assign vec0.z = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    cordic_t cin;
    if (i == 0) begin : g_first
      assign cin = vec0;
    end else begin : g_next
      assign cin = vec_w[i-1];
    end
    gcd_cordic_cell u_cell (
      .clk      (clk),
      .en       (en[ST_VEC0+i]),
      .vec_mode (1'b1),
      .shift    (SH_W'(i)),
      .atan_val (atan_entry(i)),
      .d_in     (cin),
      .d_out    (vec_w[i])
    );
  end

  // Scale by radius, by 200 (twice the angle, metres to centimetres), round, saturate.
  logic signed [DW-1:0] vz;
  logic [ZCW-1:0]       zc;
  logic [ZRW-1:0]       zr_r;
  logic [M2W-1:0]       m200_r;
  logic [M2W-1:0]       dsum;
  logic [DIST_W-1:0]    dist_r;

  always_comb begin
    vz   = vec_w[CORDIC_STAGES-1].z;
    zc   = vz[DW-1] ? '0 : vz[ZCW-1:0];
    dsum = (m200_r + (M2W'(1) << (F - 1))) >> F;
  end

  always_ff @(posedge clk) begin
    if (en[ST_RMUL]) begin
      zr_r <= ZRW'(zc) * ZRW'(radius_r);
    end
    if (en[ST_M200]) begin
      m200_r <= (M2W'(zr_r) << 7) + (M2W'(zr_r) << 6) + (M2W'(zr_r) << 3);
    end
    if (en[ST_OUT]) begin
      if (|dsum[M2W-1:DIST_W]) begin
        dist_r <= '1;
      end else begin
        dist_r <= dsum[DIST_W-1:0];
      end
    end
  end

  assign out_ch.valid       = v_r[ST_OUT];
  assign out_ch.distance_cm = dist_r;

endmodule

/* dv/gcd_checker.sv */
// Distance checker: watches the point-pair and distance channels and the config writes,
// computes each expected distance in fixed point and compares it in order.
// Depends on gcd_pkg and gcd_stream_if.
module gcd_checker (
  input  logic        clk,
  input  logic        rst_n,
  gcd_in_if.sink      in_mon,
  gcd_out_if.sink     out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gcd_pkg::*;

  localparam int F = ANGLE_FRACTION_BITS;
  localparam longint FULL_TURN = 64'sd360 <<< 22;
  localparam longint HALF_TURN = 64'sd180 <<< 22;
  localparam longint QUARTER_TURN = 64'sd90 <<< 22;
  localparam longint ONE = 64'sd1 <<< F;
  localparam longint DIST_TOP = (64'sd1 <<< 35) - 1;
  localparam logic [1:0] RADIUS_ADDR = 2'd0;

  logic [RADIUS_W-1:0] radius_m;
  logic [DIST_W-1:0]   distance_q[$];
  longint              atan_tab[CORDIC_STAGES];

  // Arctangent table from the Taylor series in Q60, rounded to Q F.
  initial begin
    longint v, term;
    int e;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      v = 0;
      if (i == 0) begin
        v = PI_Q60 >>> 2;
      end else begin
        for (int k = 0; k < 61; k++) begin
          e = 60 - i * (2 * k + 1);
          if (e < 0) break;
          term = longint'((64'd1 << e) / 64'(2 * k + 1));
          v = (k & 1) ? v - term : v + term;
        end
      end
      atan_tab[i] = (v + (64'sd1 <<< (59 - F))) >>> (60 - F);
    end
  end

  function automatic longint round_q(longint v);
    return (v + (64'sd1 <<< (F - 1))) >>> F;
  endfunction

  function automatic longint wrap_degrees(longint d);
    longint r;
    r = d % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    if (r >= HALF_TURN) r -= FULL_TURN;
    return r;
  endfunction

  function automatic longint radians_of(longint m, int extra);
    int sh;
    logic [63:0] p;
    sh = 54 - F + extra;
    p = 64'(m) * 64'(DEG2RAD_Q32) + (64'd1 << (sh - 1));
    return longint'(p >> sh);
  endfunction

  function automatic void cordic_rotate(longint z, output longint c, output longint s);
    longint x, y, nx, ny;
    x = (GAIN_Q30 + (64'sd1 <<< (29 - F))) >>> (30 - F);
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
      end
      x = nx; y = ny;
    end
    c = x; s = y;
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint half_sine_sq(longint d);
    longint r, c, s;
    r = wrap_degrees(d);
    if (r < 0) r = -r;
    cordic_rotate(radians_of(r, 1), c, s);
    return round_q(s * s);
  endfunction

  function automatic longint cosine_deg(longint a);
    longint m, c, s;
    bit neg;
    m = wrap_degrees(a);
    neg = 0;
    if (m < 0) m = -m;
    if (m > QUARTER_TURN) begin
      m = HALF_TURN - m; neg = 1;
    end
    cordic_rotate(radians_of(m, 0), c, s);
    return neg ? -c : c;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [DIST_W-1:0] distance_of(longint lat1, longint lon1,
                                                    longint lat2, longint lon2,
                                                    logic [RADIUS_W-1:0] r);
    longint hlat, hlon, cc, a, z;
    logic [63:0] sa, sb, d;
    hlat = half_sine_sq(lat2 - lat1);
    hlon = half_sine_sq(lon2 - lon1);
    cc = round_q(cosine_deg(lat1) * cosine_deg(lat2));
    a = hlat + round_q(cc * hlon);
    if (a < 0) a = 0;
    if (a > ONE) a = ONE;
    sa = int_sqrt(64'(a) << F);
    sb = int_sqrt(64'(ONE - a) << F);
    z = cordic_angle(longint'(sb), longint'(sa));
    if (z < 0) z = 0;
    d = (64'(z) * 64'd200 * 64'(r) + (64'd1 << (F - 1))) >> F;
    if (d > 64'(DIST_TOP)) d = 64'(DIST_TOP);
    return DIST_W'(d);
  endfunction

  always @(posedge clk) begin
    logic [DIST_W-1:0] want;
    if (!rst_n) begin
      radius_m <= RADIUS_RESET;
      distance_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == RADIUS_ADDR)
        radius_m <= cfg_pwdata[RADIUS_W-1:0];
      if (in_mon.valid && in_mon.ready)
        distance_q.push_back(distance_of(in_mon.first_latitude, in_mon.first_longitude,
                                         in_mon.second_latitude, in_mon.second_longitude,
                                         radius_m));
      if (out_mon.valid && out_mon.ready) begin
        if (distance_q.size() == 0) begin
          $display("%0t: distance item with none expected, actual %0d", $time,
                   out_mon.distance_cm);
          fail_count <= fail_count + 1;
        end else begin
          want = distance_q.pop_front();
          if (want !== out_mon.distance_cm) begin
            $display("%0t: distance_cm expected %0d actual %0d", $time, want,
                     out_mon.distance_cm);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= distance_q.size();
    end
  end
endmodule

/* dv/testbench.sv */
// Top of the great-circle distance testbench: clock, reset, radius writes and point pairs.
// Depends on gcd_pkg, gcd_stream_if, great_circle_distance and gcd_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gcd_pkg::*;

  localparam int LATENCY = 83;
  localparam logic [1:0] RADIUS_ADDR = 2'd0;
  localparam int LAT_MAX = 377487360;
  localparam int LON_MAX = 754974720;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending;

  gcd_in_if  in_ch();
  gcd_out_if out_ch();

  initial begin
    in_ch.valid = 0;
    in_ch.first_latitude = '0;
    in_ch.first_longitude = '0;
    in_ch.second_latitude = '0;
    in_ch.second_longitude = '0;
    out_ch.ready = 0;
  end

  great_circle_distance dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  gcd_checker check (
    .clk, .rst_n, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .fail_count, .pending
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Receiver stalls at random; some phases keep ready high throughout.
  bit steady_ready;
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else out_ch.ready <= steady_ready ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  task automatic write_radius(logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= RADIUS_ADDR; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic send_pair(int lat1, int lon1, int lat2, int lon2, bit bursty);
    int g;
    g = bursty ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.first_latitude <= LAT_W'(lat1);
    in_ch.first_longitude <= LON_W'(lon1);
    in_ch.second_latitude <= LAT_W'(lat2);
    in_ch.second_longitude <= LON_W'(lon2);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic int pick_lat();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return $urandom();
    if (p == 1) return $urandom_range(0, 1) ? LAT_MAX : -LAT_MAX;
    return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
  endfunction

  function automatic int pick_lon();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return $urandom();
    if (p == 1) return $urandom_range(0, 1) ? LON_MAX : -LON_MAX;
    return int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
  endfunction

  initial begin
    int la, lo;
    logic [31:0] radii[5];
    radii = '{32'd1, 32'd67108863, 32'd6378137, 32'd0, 32'(1 << 20)};
    steady_ready = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed pairs at the default radius: coincident, antipodal, poles, wrap edges.
    send_pair(0, 0, 0, 0, 0);
    send_pair(0, 0, 0, LON_MAX, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0, 0);
    send_pair(LAT_MAX, 123, LAT_MAX, -LON_MAX, 0);
    send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 0);
    send_pair(-LON_MAX / 2, LON_MAX, LON_MAX / 2, -LON_MAX, 0);
    send_pair(-(1 << 29), -(1 << 30), (1 << 29) - 1, (1 << 30) - 1, 0);
    send_pair(-1, -1, 0, 0, 0);
    send_pair(12345, 1, 12346, 0, 0);
    send_pair(100000000, 200000000, -100000000, -550000000, 0);
    send_pair(0, 0, 1, 0, 0);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX - 1, LON_MAX - 1, 0);
    drain();

    write_radius(32'd67108863);
    send_pair(0, 0, 0, LON_MAX, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0, 0);
    send_pair(0, 0, 4194304, 0, 0);
    drain();
    write_radius(32'd0);
    send_pair(0, 0, 0, LON_MAX, 0);
    send_pair(10, 20, 30000, 40000, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_radius(ph < 5 ? radii[ph] : $urandom_range(1, 67108863));
      steady_ready = (ph == 2);
      for (int n = 0; n < 256; n++) begin
        la = pick_lat();
        lo = pick_lon();
        if ($urandom_range(0, 3) == 0)
          send_pair(la, lo, la + int'($urandom_range(0, 2000)) - 1000,
                    lo + int'($urandom_range(0, 2000)) - 1000, ph != 2);
        else
          send_pair(la, lo, pick_lat(), pick_lon(), ph != 2);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
